// ===== hdl/lor_pkg.sv =====
`default_nettype none

package lor_pkg;

   // Fixed field widths of the item, result and register channels, and the command queue depth
   localparam int COORD_BITS     = 9;
   localparam int SIDE_BITS      = 10;
   localparam int COUNT_BITS     = 9;
   localparam int CELL_BITS      = 16;
   localparam int STEP_BITS      = 16;
   localparam int ERR_BITS       = 12;
   localparam int CSR_ADDR_BITS  = 5;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CMD_FIFO_DEPTH = 2;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [SIDE_BITS-1:0]  side_type;
   typedef logic [2:0]            reg_index_type;
   typedef logic [1:0]            status_type;

   localparam reg_index_type REG_GRID_SIDE     = 3'd0;
   localparam reg_index_type REG_FREE_STEP     = 3'd1;
   localparam reg_index_type REG_OCCUPIED_STEP = 3'd2;
   localparam reg_index_type REG_LOWER_LIMIT   = 3'd3;
   localparam reg_index_type REG_UPPER_LIMIT   = 3'd4;

   localparam status_type STATUS_TRACED   = 2'd0;
   localparam status_type STATUS_REJECTED = 2'd1;
   localparam status_type STATUS_READ     = 2'd2;

   localparam logic KIND_RAY  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam side_type GRID_SIDE_RESET = 10'd512;
   localparam logic signed [STEP_BITS-1:0] FREE_STEP_RESET     = -16'sd102;
   localparam logic signed [STEP_BITS-1:0] OCCUPIED_STEP_RESET = 16'sd218;
   localparam logic signed [STEP_BITS-1:0] LOWER_LIMIT_RESET   = -16'sd1280;
   localparam logic signed [STEP_BITS-1:0] UPPER_LIMIT_RESET   = 16'sd1280;

   typedef enum logic [1:0] {
      OP_RAY,
      OP_READ,
      OP_REJECT
   } op_type;

   typedef struct packed {
      logic      kind;
      coord_type start_col;
      coord_type start_row;
      coord_type end_col;
      coord_type end_row;
   } req_type;

   typedef struct packed {
      status_type                   status;
      logic [COUNT_BITS-1:0]        free_count;
      logic                         endpoint_hit;
      logic signed [CELL_BITS-1:0]  cell_value;
      logic                         occupied;
   } rsp_type;

   // Classified work item handed from the front to the back
   typedef struct packed {
      op_type    op;
      coord_type start_col;
      coord_type start_row;
      coord_type end_col;
      coord_type end_row;
      logic      end_in;
      coord_type dx;
      coord_type dy;
      logic      step_x_pos;
      logic      step_y_pos;
   } cmd_type;

   function automatic logic in_grid(coord_type col, coord_type row, side_type side);
      return ({1'b0, col} < side) && ({1'b0, row} < side);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/lor_ram.sv =====
`default_nettype none

module lor_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 262144
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/lor_front.sv =====
`default_nettype none

module lor_front (
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire lor_pkg::req_type  req_data,
   input  wire lor_pkg::side_type side,
   input  wire logic              hold,
   input  wire logic              cmd_full,
   output logic                   cmd_push,
   output lor_pkg::cmd_type       cmd
);

   logic start_in;
   logic end_in;
   logic is_read;

   always_comb begin
      start_in = lor_pkg::in_grid(req_data.start_col, req_data.start_row, side);
      end_in   = lor_pkg::in_grid(req_data.end_col, req_data.end_row, side);
      is_read  = (req_data.kind == lor_pkg::KIND_READ);

      cmd.start_col = req_data.start_col;
      cmd.start_row = req_data.start_row;
      cmd.step_x_pos = (req_data.start_col < req_data.end_col);
      cmd.step_y_pos = (req_data.start_row < req_data.end_row);
      cmd.dx = (req_data.end_col > req_data.start_col) ?
               req_data.end_col - req_data.start_col :
               req_data.start_col - req_data.end_col;
      cmd.dy = (req_data.end_row > req_data.start_row) ?
               req_data.end_row - req_data.start_row :
               req_data.start_row - req_data.end_row;

      // A read targets its own start cell; a rejected ray touches nothing
      priority if (is_read) begin
         cmd.op      = lor_pkg::OP_READ;
         cmd.end_col = req_data.start_col;
         cmd.end_row = req_data.start_row;
         cmd.end_in  = start_in;
      end else if (!start_in) begin
         cmd.op      = lor_pkg::OP_REJECT;
         cmd.end_col = req_data.end_col;
         cmd.end_row = req_data.end_row;
         cmd.end_in  = 1'b0;
      end else begin
         cmd.op      = lor_pkg::OP_RAY;
         cmd.end_col = req_data.end_col;
         cmd.end_row = req_data.end_row;
         cmd.end_in  = end_in;
      end
   end

   assign req_ready = !hold && !cmd_full;
   assign cmd_push  = req_valid && req_ready;

endmodule

`default_nettype wire

// ===== hdl/lor_cmd_fifo.sv =====
`default_nettype none

module lor_cmd_fifo (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire lor_pkg::cmd_type push_data,
   output logic                  full,
   input  wire logic             pop,
   output lor_pkg::cmd_type      pop_data,
   output logic                  not_empty
);

   localparam int PTR_BITS = $clog2(lor_pkg::CMD_FIFO_DEPTH);
   localparam int CNT_BITS = PTR_BITS + 1;
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(lor_pkg::CMD_FIFO_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(lor_pkg::CMD_FIFO_DEPTH);

   lor_pkg::cmd_type      slot_ff [lor_pkg::CMD_FIFO_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && not_empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== hdl/lor_back.sv =====
`default_nettype none

module lor_back #(
   parameter int MAX_SIDE   = 512,
   parameter int VALUE_BITS = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire lor_pkg::cmd_type                       cmd,
   input  wire logic                                   cmd_valid,
   output logic                                        cmd_pop,
   input  wire lor_pkg::side_type                      side,
   input  wire logic signed [lor_pkg::STEP_BITS-1:0]   free_step,
   input  wire logic signed [lor_pkg::STEP_BITS-1:0]   occupied_step,
   input  wire logic signed [lor_pkg::STEP_BITS-1:0]   lower_limit,
   input  wire logic signed [lor_pkg::STEP_BITS-1:0]   upper_limit,
   output logic                                        clearing,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output lor_pkg::rsp_type                            rsp_data
);

   localparam int DEPTH     = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int SUM_BITS  =
      ((VALUE_BITS > lor_pkg::STEP_BITS) ? VALUE_BITS : lor_pkg::STEP_BITS) + 2;
   localparam int ERR_BITS  = lor_pkg::ERR_BITS;
   localparam logic [ADDR_BITS-1:0] SIDE_ADDR = ADDR_BITS'(MAX_SIDE);
   localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(DEPTH - 1);
   localparam logic signed [SUM_BITS-1:0] VALUE_MAX =
      SUM_BITS'((64'd1 << (VALUE_BITS - 1)) - 64'd1);
   localparam logic signed [SUM_BITS-1:0] VALUE_MIN = ~VALUE_MAX;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_HIT_RD,
      ST_HIT_WR
   } state_type;

   function automatic logic [ADDR_BITS-1:0] cell_addr(lor_pkg::coord_type col,
                                                      lor_pkg::coord_type row);
      return ADDR_BITS'(row) * SIDE_ADDR + ADDR_BITS'(col);
   endfunction

   function automatic logic signed [SUM_BITS-1:0] sat_value(
      logic signed [SUM_BITS-1:0] v);
      if (v > VALUE_MAX) begin
         return VALUE_MAX;
      end else if (v < VALUE_MIN) begin
         return VALUE_MIN;
      end
      return v;
   endfunction

   state_type                          state_ff, state_in;
   lor_pkg::coord_type                 x_ff, x_in;
   lor_pkg::coord_type                 y_ff, y_in;
   logic signed [ERR_BITS-1:0]         err_ff, err_in;
   lor_pkg::coord_type                 dx_ff, dx_in;
   lor_pkg::coord_type                 dy_ff, dy_in;
   logic                               stx_ff, stx_in;
   logic                               sty_ff, sty_in;
   lor_pkg::coord_type                 end_col_ff, end_col_in;
   lor_pkg::coord_type                 end_row_ff, end_row_in;
   logic                               end_in_ff, end_in_in;
   lor_pkg::op_type                    op_ff, op_in;
   logic [lor_pkg::COUNT_BITS-1:0]     fcount_ff, fcount_in;
   logic                               pend_ff, pend_in;
   logic [ADDR_BITS-1:0]               pend_addr_ff, pend_addr_in;
   logic [ADDR_BITS-1:0]               clr_ff, clr_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   lor_pkg::rsp_type                   rsp_ff, rsp_in;

   logic                               ram_wr_en;
   logic [ADDR_BITS-1:0]               ram_wr_addr;
   logic [VALUE_BITS-1:0]              ram_wr_data;
   logic                               ram_rd_en;
   logic [ADDR_BITS-1:0]               ram_rd_addr;
   logic [VALUE_BITS-1:0]              ram_rd_data;

   logic                               at_end;
   logic                               here_in;
   logic                               out_free;
   logic                               hit_write;
   logic signed [ERR_BITS:0]           e2;
   logic signed [ERR_BITS:0]           dx_s;
   logic signed [ERR_BITS:0]           dy_s;
   logic signed [ERR_BITS:0]           err_next;
   logic                               move_x;
   logic                               move_y;
   logic signed [SUM_BITS-1:0]         old_value;
   logic signed [SUM_BITS-1:0]         free_sum;
   logic signed [SUM_BITS-1:0]         free_new;
   logic signed [SUM_BITS-1:0]         hit_sum;
   logic signed [SUM_BITS-1:0]         hit_new;
   logic signed [SUM_BITS-1:0]         result_value;

   lor_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Bresenham step and read-modify-write arithmetic
   always_comb begin
      at_end   = (x_ff == end_col_ff) && (y_ff == end_row_ff);
      here_in  = lor_pkg::in_grid(x_ff, y_ff, side);
      out_free = !rsp_valid_ff || rsp_ready;

      e2       = {err_ff, 1'b0};
      dx_s     = signed'((ERR_BITS + 1)'(dx_ff));
      dy_s     = signed'((ERR_BITS + 1)'(dy_ff));
      move_x   = (e2 > -dy_s);
      move_y   = (e2 < dx_s);
      err_next = (ERR_BITS + 1)'(err_ff) - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);

      old_value = SUM_BITS'(signed'(ram_rd_data));
      free_sum  = sat_value(old_value + SUM_BITS'(free_step));
      free_new  = sat_value((free_sum < SUM_BITS'(lower_limit)) ?
                            SUM_BITS'(lower_limit) : free_sum);
      hit_sum   = sat_value(old_value + SUM_BITS'(occupied_step));
      hit_new   = sat_value((hit_sum > SUM_BITS'(upper_limit)) ?
                            SUM_BITS'(upper_limit) : hit_sum);

      hit_write = (state_ff == ST_HIT_WR) && (op_ff == lor_pkg::OP_RAY) && end_in_ff;
   end

   // Store write port: clearing pass, then pipelined free writes, then the hit cell
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = pend_addr_ff;
      ram_wr_data = VALUE_BITS'(free_new);
      priority if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = '0;
      end else if (pend_ff) begin
         ram_wr_en   = 1'b1;
      end else if (hit_write) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = cell_addr(end_col_ff, end_row_ff);
         ram_wr_data = VALUE_BITS'(hit_new);
      end else begin
         ram_wr_en   = 1'b0;
      end
   end

   always_comb begin
      state_in     = state_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      err_in       = err_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      stx_in       = stx_ff;
      sty_in       = sty_ff;
      end_col_in   = end_col_ff;
      end_row_in   = end_row_ff;
      end_in_in    = end_in_ff;
      op_in        = op_ff;
      fcount_in    = fcount_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = cell_addr(x_ff, y_ff);
      result_value = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + ADDR_BITS'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop    = 1'b1;
               x_in       = cmd.start_col;
               y_in       = cmd.start_row;
               dx_in      = cmd.dx;
               dy_in      = cmd.dy;
               err_in     = ERR_BITS'(cmd.dx) - ERR_BITS'(cmd.dy);
               stx_in     = cmd.step_x_pos;
               sty_in     = cmd.step_y_pos;
               end_col_in = cmd.end_col;
               end_row_in = cmd.end_row;
               end_in_in  = cmd.end_in;
               op_in      = cmd.op;
               fcount_in  = '0;
               state_in   = (cmd.op == lor_pkg::OP_RAY) ? ST_WALK : ST_HIT_RD;
            end
         end
         ST_WALK: begin
            if (at_end) begin
               state_in = ST_HIT_RD;
            end else begin
               // Read this cell now, update it next cycle
               ram_rd_en    = here_in;
               pend_in      = here_in;
               pend_addr_in = cell_addr(x_ff, y_ff);
               if (here_in) begin
                  fcount_in = fcount_ff + lor_pkg::COUNT_BITS'(1);
               end
               err_in = ERR_BITS'(err_next);
               if (move_x) begin
                  x_in = stx_ff ? x_ff + lor_pkg::COORD_BITS'(1) :
                                  x_ff - lor_pkg::COORD_BITS'(1);
               end
               if (move_y) begin
                  y_in = sty_ff ? y_ff + lor_pkg::COORD_BITS'(1) :
                                  y_ff - lor_pkg::COORD_BITS'(1);
               end
            end
         end
         ST_HIT_RD: begin
            // Hold until the result register can take this item's result
            ram_rd_addr = cell_addr(end_col_ff, end_row_ff);
            if (out_free) begin
               ram_rd_en = end_in_ff;
               state_in  = ST_HIT_WR;
            end
         end
         ST_HIT_WR: begin
            unique case (op_ff)
               lor_pkg::OP_RAY: begin
                  rsp_in.status = lor_pkg::STATUS_TRACED;
                  result_value  = end_in_ff ? hit_new : '0;
               end
               lor_pkg::OP_READ: begin
                  rsp_in.status = lor_pkg::STATUS_READ;
                  result_value  = end_in_ff ? old_value : '0;
               end
               default: begin
                  rsp_in.status = lor_pkg::STATUS_REJECTED;
                  result_value  = '0;
               end
            endcase
            rsp_in.free_count   = fcount_ff;
            rsp_in.endpoint_hit = hit_write;
            rsp_in.cell_value   = result_value[lor_pkg::CELL_BITS-1:0];
            rsp_in.occupied     = (result_value > SUM_BITS'(0));
            rsp_valid_in        = 1'b1;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff         <= x_in;
      y_ff         <= y_in;
      err_ff       <= err_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      stx_ff       <= stx_in;
      sty_ff       <= sty_in;
      end_col_ff   <= end_col_in;
      end_row_ff   <= end_row_in;
      end_in_ff    <= end_in_in;
      op_ff        <= op_in;
      fcount_ff    <= fcount_in;
      pend_addr_ff <= pend_addr_in;
      rsp_ff       <= rsp_in;
   end

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/log_odds_ray_update.sv =====
`default_nettype none

// Occupancy-grid ray update over a MAX_SIDE x MAX_SIDE store of signed log-odds values.
// After reset the store is cleared to zero one entry per cycle, and req_ready stays low
// until that pass ends; the APB registers can be written throughout. For a ray, the back
// end's Bresenham walker visits one cell per cycle, reading it from the store and writing
// the updated value in the next cycle on the second port, then reads and writes the hit
// cell. A two-entry command queue lets new items in while the back end is busy, and
// results wait in an output register.
module log_odds_ray_update #(
   parameter int MAX_SIDE   = 512,
   parameter int VALUE_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire lor_pkg::req_type                     req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output lor_pkg::rsp_type                          rsp_data,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [lor_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  wire logic [lor_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic      [lor_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                      pready
);

   localparam lor_pkg::side_type MAX_SIDE_CLIP =
      (MAX_SIDE > 1023) ? '1 : lor_pkg::SIDE_BITS'(MAX_SIDE);

   lor_pkg::side_type                      grid_side_ff;
   logic signed [lor_pkg::STEP_BITS-1:0]   free_step_ff;
   logic signed [lor_pkg::STEP_BITS-1:0]   occupied_step_ff;
   logic signed [lor_pkg::STEP_BITS-1:0]   lower_limit_ff;
   logic signed [lor_pkg::STEP_BITS-1:0]   upper_limit_ff;

   lor_pkg::reg_index_type                 reg_index;
   logic                                   csr_write;
   lor_pkg::side_type                      side;
   logic                                   clearing;
   logic                                   cmd_push;
   logic                                   cmd_full;
   logic                                   cmd_pop;
   logic                                   cmd_not_empty;
   lor_pkg::cmd_type                       front_cmd;
   lor_pkg::cmd_type                       back_cmd;

   assign reg_index = paddr[4:2];
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign side      = (grid_side_ff < MAX_SIDE_CLIP) ? grid_side_ff : MAX_SIDE_CLIP;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_side_ff     <= lor_pkg::GRID_SIDE_RESET;
         free_step_ff     <= lor_pkg::FREE_STEP_RESET;
         occupied_step_ff <= lor_pkg::OCCUPIED_STEP_RESET;
         lower_limit_ff   <= lor_pkg::LOWER_LIMIT_RESET;
         upper_limit_ff   <= lor_pkg::UPPER_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            lor_pkg::REG_GRID_SIDE:     grid_side_ff     <= pwdata[lor_pkg::SIDE_BITS-1:0];
            lor_pkg::REG_FREE_STEP:     free_step_ff     <= pwdata[lor_pkg::STEP_BITS-1:0];
            lor_pkg::REG_OCCUPIED_STEP: occupied_step_ff <= pwdata[lor_pkg::STEP_BITS-1:0];
            lor_pkg::REG_LOWER_LIMIT:   lower_limit_ff   <= pwdata[lor_pkg::STEP_BITS-1:0];
            lor_pkg::REG_UPPER_LIMIT:   upper_limit_ff   <= pwdata[lor_pkg::STEP_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         lor_pkg::REG_GRID_SIDE:     prdata = lor_pkg::CSR_DATA_BITS'(grid_side_ff);
         lor_pkg::REG_FREE_STEP:     prdata = lor_pkg::CSR_DATA_BITS'(free_step_ff);
         lor_pkg::REG_OCCUPIED_STEP: prdata = lor_pkg::CSR_DATA_BITS'(occupied_step_ff);
         lor_pkg::REG_LOWER_LIMIT:   prdata = lor_pkg::CSR_DATA_BITS'(lower_limit_ff);
         lor_pkg::REG_UPPER_LIMIT:   prdata = lor_pkg::CSR_DATA_BITS'(upper_limit_ff);
         default:                    prdata = '0;
      endcase
   end

   lor_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .side      (side),
      .hold      (clearing),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd       (front_cmd)
   );

   lor_cmd_fifo u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (back_cmd),
      .not_empty (cmd_not_empty)
   );

   lor_back #(
      .MAX_SIDE   (MAX_SIDE),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd           (back_cmd),
      .cmd_valid     (cmd_not_empty),
      .cmd_pop       (cmd_pop),
      .side          (side),
      .free_step     (free_step_ff),
      .occupied_step (occupied_step_ff),
      .lower_limit   (lower_limit_ff),
      .upper_limit   (upper_limit_ff),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule

`default_nettype wire

// ===== tb/log_odds_ray_update_test.sv =====
`default_nettype none

module log_odds_ray_update_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAP_SIDE     = 512;
   localparam int SETTLE_TICKS = 600;
   localparam int ROW_COUNT    = 23;

   typedef struct packed {
      lor_pkg::req_type item;
      logic             pinned;
      lor_pkg::rsp_type want;
   } directed_row_type;

   // Pinned rows hold results that follow directly from the cleared store.
   localparam directed_row_type DIRECTED_ROWS [ROW_COUNT] = '{
      '{'{lor_pkg::KIND_READ, 9'd0, 9'd0, 9'd511, 9'd511}, 1'b1,
        '{lor_pkg::STATUS_READ, 9'd0, 1'b0, 16'sd0, 1'b0}},
      '{'{lor_pkg::KIND_READ, 9'd511, 9'd511, 9'd0, 9'd0}, 1'b1,
        '{lor_pkg::STATUS_READ, 9'd0, 1'b0, 16'sd0, 1'b0}},
      '{'{lor_pkg::KIND_RAY, 9'd0, 9'd0, 9'd0, 9'd0}, 1'b1,
        '{lor_pkg::STATUS_TRACED, 9'd0, 1'b1, 16'sd218, 1'b1}},
      '{'{lor_pkg::KIND_READ, 9'd0, 9'd0, 9'd0, 9'd0}, 1'b1,
        '{lor_pkg::STATUS_READ, 9'd0, 1'b0, 16'sd218, 1'b1}},
      '{'{lor_pkg::KIND_RAY, 9'd0, 9'd0, 9'd511, 9'd511}, 1'b1,
        '{lor_pkg::STATUS_TRACED, 9'd511, 1'b1, 16'sd218, 1'b1}},
      '{'{lor_pkg::KIND_RAY, 9'd511, 9'd0, 9'd0, 9'd511}, 1'b0, '0},
      '{'{lor_pkg::KIND_RAY, 9'd511, 9'd511, 9'd0, 9'd0}, 1'b0, '0},
      '{'{lor_pkg::KIND_RAY, 9'd300, 9'd0, 9'd300, 9'd511}, 1'b0, '0},
      '{'{lor_pkg::KIND_RAY, 9'd511, 9'd300, 9'd0, 9'd300}, 1'b0, '0},
      '{'{lor_pkg::KIND_RAY, 9'd10, 9'd10, 9'd40, 9'd17}, 1'b0, '0},
      '{'{lor_pkg::KIND_RAY, 9'd40, 9'd17, 9'd10, 9'd10}, 1'b0, '0},
      '{'{lor_pkg::KIND_RAY, 9'd100, 9'd100, 9'd93, 9'd140}, 1'b0, '0},
      '{'{lor_pkg::KIND_RAY, 9'd100, 9'd100, 9'd130, 9'd95}, 1'b0, '0},
      '{'{lor_pkg::KIND_RAY, 9'd256, 9'd256, 9'd255, 9'd0}, 1'b0, '0},
      '{'{lor_pkg::KIND_RAY, 9'd5, 9'd5, 9'd9, 9'd5}, 1'b0, '0},
      '{'{lor_pkg::KIND_RAY, 9'd5, 9'd5, 9'd9, 9'd5}, 1'b0, '0},
      '{'{lor_pkg::KIND_RAY, 9'd5, 9'd5, 9'd9, 9'd5}, 1'b0, '0},
      '{'{lor_pkg::KIND_RAY, 9'd5, 9'd5, 9'd9, 9'd5}, 1'b0, '0},
      '{'{lor_pkg::KIND_RAY, 9'd5, 9'd5, 9'd9, 9'd5}, 1'b0, '0},
      '{'{lor_pkg::KIND_RAY, 9'd5, 9'd5, 9'd9, 9'd5}, 1'b0, '0},
      '{'{lor_pkg::KIND_READ, 9'd9, 9'd5, 9'd170, 9'd341}, 1'b0, '0},
      '{'{lor_pkg::KIND_READ, 9'd7, 9'd5, 9'd0, 9'd0}, 1'b0, '0},
      '{'{lor_pkg::KIND_READ, 9'd256, 9'd128, 9'd0, 9'd0}, 1'b0, '0}
   };

   logic                              clock     = 1'b0;
   logic                              reset     = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   lor_pkg::req_type                  req_data  = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   lor_pkg::rsp_type                  rsp_data;
   logic                              psel      = 1'b0;
   logic                              penable   = 1'b0;
   logic                              pwrite    = 1'b0;
   logic [lor_pkg::CSR_ADDR_BITS-1:0] paddr     = '0;
   logic [lor_pkg::CSR_DATA_BITS-1:0] pwdata    = '0;
   logic [lor_pkg::CSR_DATA_BITS-1:0] prdata;
   logic                              pready;

   // Mirror of the grid and its settings
   shortint log_odds [MAP_SIDE*MAP_SIDE];
   int side_cfg  = lor_pkg::GRID_SIDE_RESET;
   int free_cfg  = lor_pkg::FREE_STEP_RESET;
   int occ_cfg   = lor_pkg::OCCUPIED_STEP_RESET;
   int lower_cfg = lor_pkg::LOWER_LIMIT_RESET;
   int upper_cfg = lor_pkg::UPPER_LIMIT_RESET;

   lor_pkg::rsp_type pending_results [$];
   lor_pkg::req_type recent_rays [$];
   int               sent_count  = 0;
   int               taken_count = 0;
   int               fail_count  = 0;

   log_odds_ray_update u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #6 clock = ~clock;

   function automatic int sat_q(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   function automatic bit on_map(int col, int row, int side);
      return col < side && row < side;
   endfunction

   // Apply one item to the mirror and return the result it should produce.
   function automatic lor_pkg::rsp_type update_grid(lor_pkg::req_type item);
      lor_pkg::rsp_type r;
      int      side, sc, sr, ec, er, col, row, dx, dy, sx, sy, err, e2, cnt, idx;
      longint  v;
      r    = '0;
      side = (side_cfg < MAP_SIDE) ? side_cfg : MAP_SIDE;
      sc   = int'(item.start_col);
      sr   = int'(item.start_row);
      ec   = int'(item.end_col);
      er   = int'(item.end_row);
      if (item.kind == lor_pkg::KIND_READ) begin
         r.status = lor_pkg::STATUS_READ;
         if (on_map(sc, sr, side)) r.cell_value = log_odds[sr*MAP_SIDE + sc];
      end else if (!on_map(sc, sr, side)) begin
         r.status = lor_pkg::STATUS_REJECTED;
      end else begin
         r.status = lor_pkg::STATUS_TRACED;
         col = sc;
         row = sr;
         dx  = (ec > sc) ? ec - sc : sc - ec;
         dy  = (er > sr) ? er - sr : sr - er;
         sx  = (sc < ec) ? 1 : -1;
         sy  = (sr < er) ? 1 : -1;
         err = dx - dy;
         cnt = 0;
         while (!(col == ec && row == er)) begin
            if (on_map(col, row, side)) begin
               idx = row*MAP_SIDE + col;
               v   = sat_q(longint'(log_odds[idx]) + free_cfg);
               if (v < lower_cfg) v = lower_cfg;
               log_odds[idx] = shortint'(v);
               cnt++;
            end
            e2 = 2*err;
            if (e2 > -dy) begin
               err -= dy;
               col += sx;
            end
            if (e2 < dx) begin
               err += dx;
               row += sy;
            end
         end
         r.free_count = lor_pkg::COUNT_BITS'(cnt);
         if (on_map(ec, er, side)) begin
            idx = er*MAP_SIDE + ec;
            v   = sat_q(longint'(log_odds[idx]) + occ_cfg);
            if (v > upper_cfg) v = upper_cfg;
            log_odds[idx]  = shortint'(v);
            r.endpoint_hit = 1'b1;
            r.cell_value   = lor_pkg::CELL_BITS'(v);
         end
      end
      r.occupied = ($signed(r.cell_value) > 0);
      return r;
   endfunction

   function automatic lor_pkg::coord_type pick_coord(int reach);
      if ($urandom_range(0, 7) == 0) return lor_pkg::coord_type'($urandom);
      return lor_pkg::coord_type'($urandom_range(0, reach));
   endfunction

   function automatic lor_pkg::coord_type nudge(lor_pkg::coord_type c);
      int v;
      v = int'(c) + int'($urandom_range(0, 24)) - 12;
      if (v < 0) v = 0;
      if (v > MAP_SIDE - 1) v = MAP_SIDE - 1;
      return lor_pkg::coord_type'(v);
   endfunction

   function automatic int pick_step();
      if ($urandom_range(0, 3) == 0) return int'($signed(16'($urandom)));
      return int'($urandom_range(0, 800)) - 400;
   endfunction

   // Mostly short rays and reads around the grid in use; now and then a long ray.
   function automatic lor_pkg::req_type random_item(int span);
      lor_pkg::req_type it;
      lor_pkg::req_type old;
      int               reach;
      reach        = (span + 1 > MAP_SIDE - 1) ? MAP_SIDE - 1 : span + 1;
      it.kind      = ($urandom_range(0, 9) < 3) ? lor_pkg::KIND_READ : lor_pkg::KIND_RAY;
      it.start_col = pick_coord(reach);
      it.start_row = pick_coord(reach);
      if ($urandom_range(0, 29) == 0) begin
         it.end_col = lor_pkg::coord_type'($urandom);
         it.end_row = lor_pkg::coord_type'($urandom);
      end else begin
         it.end_col = nudge(it.start_col);
         it.end_row = nudge(it.start_row);
      end
      // revisit cells that recent rays touched
      if (it.kind == lor_pkg::KIND_READ && recent_rays.size() != 0 &&
          $urandom_range(0, 1) == 1) begin
         old = recent_rays[$urandom_range(0, recent_rays.size() - 1)];
         if ($urandom_range(0, 1) == 1) begin
            it.start_col = old.end_col;
            it.start_row = old.end_row;
         end else begin
            it.start_col = old.start_col;
            it.start_row = old.start_row;
         end
      end
      return it;
   endfunction

   task automatic report_field(string what, int want, int got);
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fail_count++;
   endtask

   // Write one register, read it back, and update the mirror. Call at a falling edge.
   task automatic set_register(lor_pkg::reg_index_type idx, int value);
      logic [lor_pkg::CSR_DATA_BITS-1:0] seen;
      logic [lor_pkg::CSR_DATA_BITS-1:0] mask;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      seen = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         lor_pkg::REG_GRID_SIDE:     side_cfg  = value & 32'h3FF;
         lor_pkg::REG_FREE_STEP:     free_cfg  = int'(shortint'(value));
         lor_pkg::REG_OCCUPIED_STEP: occ_cfg   = int'(shortint'(value));
         lor_pkg::REG_LOWER_LIMIT:   lower_cfg = int'(shortint'(value));
         lor_pkg::REG_UPPER_LIMIT:   upper_cfg = int'(shortint'(value));
         default: ;
      endcase
      mask = (idx == lor_pkg::REG_GRID_SIDE) ? 32'h3FF : 32'hFFFF;
      if (((seen ^ value) & mask) != 0)
         report_field($sformatf("register %0d readback", idx), value & mask, seen & mask);
   endtask

   // Hold the sender off until every pending result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Call at a falling edge; returns at the falling edge after the transfer.
   task automatic send_item(lor_pkg::req_type item, logic pinned, lor_pkg::rsp_type want);
      int               gap;
      lor_pkg::rsp_type predicted;
      gap = (sent_count % 50 < 12) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = update_grid(item);
      pending_results.insert(pending_results.size(), pinned ? want : predicted);
      sent_count++;
      if (item.kind == lor_pkg::KIND_RAY) begin
         recent_rays.insert(recent_rays.size(), item);
         if (recent_rays.size() > 16) void'(recent_rays.pop_front());
      end
      @(negedge clock);
   endtask

   task automatic run_phase(int side, int free_inc, int occ_inc, int floor_q, int ceil_q,
                            int items, bit with_rows);
      int span;
      set_register(lor_pkg::REG_GRID_SIDE, side);
      set_register(lor_pkg::REG_FREE_STEP, free_inc);
      set_register(lor_pkg::REG_OCCUPIED_STEP, occ_inc);
      set_register(lor_pkg::REG_LOWER_LIMIT, floor_q);
      set_register(lor_pkg::REG_UPPER_LIMIT, ceil_q);
      if (with_rows) begin
         for (int i = 0; i < ROW_COUNT; i++)
            send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);
      end
      span = (side_cfg < MAP_SIDE) ? side_cfg : MAP_SIDE;
      for (int n = 0; n < items; n++) begin
         if (n == items/2) drain_results();
         send_item(random_item(span), 1'b0, '0);
      end
      drain_results();
   endtask

   initial begin : result_side
      lor_pkg::rsp_type want;
      int               gap;
      while (reset) @(negedge clock);
      forever begin
         gap = (taken_count % 70 < 15) ? 0 : $urandom_range(0, 19);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken_count++;
         if (pending_results.size() == 0) begin
            $display("%0t ns: unexpected transfer, expected none, actual %h", $time, rsp_data);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status)
               report_field("status", want.status, rsp_data.status);
            if (rsp_data.free_count !== want.free_count)
               report_field("free_count", want.free_count, rsp_data.free_count);
            if (rsp_data.endpoint_hit !== want.endpoint_hit)
               report_field("endpoint_hit", want.endpoint_hit, rsp_data.endpoint_hit);
            if (rsp_data.cell_value !== want.cell_value)
               report_field("cell_value", $signed(want.cell_value),
                            $signed(rsp_data.cell_value));
            if (rsp_data.occupied !== want.occupied)
               report_field("occupied", want.occupied, rsp_data.occupied);
         end
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int side;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_phase(lor_pkg::GRID_SIDE_RESET, lor_pkg::FREE_STEP_RESET,
                lor_pkg::OCCUPIED_STEP_RESET, lor_pkg::LOWER_LIMIT_RESET,
                lor_pkg::UPPER_LIMIT_RESET, 150, 1'b1);
      // saturate both ways with a side beyond the store
      run_phase(1023, -32768, 32767, -32768, 32767, 100, 1'b0);
      // empty grid: every ray rejected, every read zero
      run_phase(0, -102, 218, -1280, 1280, 40, 1'b0);
      run_phase(1, 5, 7, -3, 9, 60, 1'b0);
      run_phase(24, -200, 300, -500, 700, 150, 1'b0);
      run_phase(512, 32767, -32768, 32767, -32768, 80, 1'b0);
      run_phase(100, 77, -55, 100, -100, 80, 1'b0);
      for (int p = 0; p < 5; p++) begin
         case ($urandom_range(0, 5))
            4:       side = 512;
            5:       side = $urandom_range(513, 1023);
            default: side = $urandom_range(2, 64);
         endcase
         run_phase(side, pick_step(), pick_step(), pick_step(), pick_step(), 100, 1'b0);
      end
      // catch any stray transfer
      repeat (SETTLE_TICKS) @(posedge clock);
      if (fail_count == 0) begin
         $display("log_odds_ray_update regression: pass");
      end else begin
         $display("log_odds_ray_update regression: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #60_000_000;
      $display("log_odds_ray_update regression: fail");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
hdl/lor_pkg.sv
hdl/lor_ram.sv
hdl/lor_front.sv
hdl/lor_cmd_fifo.sv
hdl/lor_back.sv
hdl/log_odds_ray_update.sv
tb/log_odds_ray_update_test.sv
